// ===== rtl/core/pif_pkg.sv =====
`default_nettype none

package pif_pkg;

	// Raw value and decimal conversion sizes.
	localparam int VALUE_W    = 64;
	localparam int STEP_W     = 6;
	localparam int BCD_DIGITS = 20;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int NDIG_W     = 5;
	localparam int CHAR_W     = 8;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_CONV_UNSIGNED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH_MODE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_JUSTIFY  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLUS_SIGN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPACE_SIGN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PRECISION_ON  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DIGITS    = 3'd7;

	// Length codes; the unused code behaves as int.
	localparam logic [1:0] LEN_INT   = 2'd0;
	localparam logic [1:0] LEN_SHORT = 2'd1;
	localparam logic [1:0] LEN_LONG  = 2'd2;

	// ASCII characters.
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	typedef struct packed {
		logic       conv_unsigned;
		logic [1:0] length_mode;
		logic       left_justify;
		logic       plus_sign;
		logic       space_sign;
		logic [6:0] field_width;
		logic       precision_on;
		logic [5:0] min_digits;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic dabble;
		logic norm;
		logic layout;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic norm_done;
		logic out_free;
		logic last;
	} sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_NORM,
		ST_LAYOUT,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/core/printf_integer_formatter.sv =====
`default_nettype none

// Channel   | Direction | Signals                             | Contents
// ----------+-----------+-------------------------------------+------------------------------
// s_axis    | in        | s_axis_tvalid/tready/tdata[63:0]    | value_bits
// m_axis    | out       | m_axis_tvalid/tready/tdata[7:0]     | char_out, tlast = last_char
// cfg       | in        | cfg_we, cfg_index[2:0], cfg_data    | register writes, no read-back
//
// Each value is loaded, shifted 64 times from binary to decimal through a 20-digit
// shift-and-add-three register, stripped of leading zero digits (up to 19 shifts, then
// a final step that finds the leading digit) and laid out; its characters then leave
// one per cycle while the output is not stalled: max(field width, text length) of them.
// The conversion loop and the one-character-per-cycle output register set the rate.
// Output stalls on m_axis_tready simply hold the emitter; the next value is taken once the
// final character of a field sits in the output register.
// Reset is asynchronous and clears the configuration and the control state; there is no
// clearing pass.

module printf_integer_formatter #(
	parameter int MAX_FIELD = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,

	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [pif_pkg::VALUE_W-1:0]         s_axis_tdata,   // [63:0] value_bits

	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output logic [pif_pkg::CHAR_W-1:0]               m_axis_tdata,   // [7:0] char_out
	output logic                                     m_axis_tlast,

	input  wire logic                                cfg_we,
	input  wire logic [pif_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [pif_pkg::CFG_DATA_W-1:0]      cfg_data
);

	pif_pkg::cfg_t cfg_q;
	pif_pkg::cmd_t cmd;
	pif_pkg::sts_t sts;

	// Configuration registers. Each write keeps only the bits its register holds, so a
	// wider value written to a narrow register is cut to its low bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pif_pkg::REG_CONV_UNSIGNED: cfg_q.conv_unsigned <= cfg_data[0];
				pif_pkg::REG_LENGTH_MODE:   cfg_q.length_mode   <= cfg_data[1:0];
				pif_pkg::REG_LEFT_JUSTIFY:  cfg_q.left_justify  <= cfg_data[0];
				pif_pkg::REG_PLUS_SIGN:     cfg_q.plus_sign     <= cfg_data[0];
				pif_pkg::REG_SPACE_SIGN:    cfg_q.space_sign    <= cfg_data[0];
				pif_pkg::REG_FIELD_WIDTH:   cfg_q.field_width   <= cfg_data[6:0];
				pif_pkg::REG_PRECISION_ON:  cfg_q.precision_on  <= cfg_data[0];
				pif_pkg::REG_MIN_DIGITS:    cfg_q.min_digits    <= cfg_data[5:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// The controller sequences load, conversion, normalisation, layout and emission.
	pif_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the magnitude, the decimal digits, the layout counters and the
	// output register that parts the emitter from the downstream transaction.
	pif_dp #(
		.MAX_FIELD (MAX_FIELD)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.value_bits (s_axis_tdata),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.char_out   (m_axis_tdata),
		.last_char  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ===== rtl/core/pif_ctrl.sv =====
`default_nettype none

module pif_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire pif_pkg::sts_t sts,
	output pif_pkg::cmd_t      cmd
);

	pif_pkg::state_t                 state_q;
	pif_pkg::state_t                 state_d;
	logic [pif_pkg::STEP_W-1:0]      step_q;
	logic                            step_end;

	assign step_end = (step_q == {pif_pkg::STEP_W{1'b1}});

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pif_pkg::ST_IDLE: begin
				if (in_valid) state_d = pif_pkg::ST_CONV;
			end
			pif_pkg::ST_CONV: begin
				if (step_end) state_d = pif_pkg::ST_NORM;
			end
			pif_pkg::ST_NORM: begin
				if (sts.norm_done) state_d = pif_pkg::ST_LAYOUT;
			end
			pif_pkg::ST_LAYOUT: begin
				state_d = pif_pkg::ST_EMIT;
			end
			pif_pkg::ST_EMIT: begin
				if (sts.out_free && sts.last) state_d = pif_pkg::ST_IDLE;
			end
			default: begin
				state_d = pif_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			pif_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			pif_pkg::ST_CONV: begin
				cmd.dabble = 1'b1;
			end
			pif_pkg::ST_NORM: begin
				cmd.norm = !sts.norm_done;
			end
			pif_pkg::ST_LAYOUT: begin
				cmd.layout = 1'b1;
			end
			pif_pkg::ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pif_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.dabble) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Conversion always runs the full bit count before normalising.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pif_pkg::ST_CONV && step_end) |=> state_q == pif_pkg::ST_NORM)
		else $error("conversion did not hand over to normalisation");

	// A new value is only taken once the previous field's final character is in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> $past(state_q) == pif_pkg::ST_IDLE || $past(state_q) == pif_pkg::ST_EMIT)
		else $error("value loaded in the middle of a conversion");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pif_pkg::ST_CONV) |-> !in_ready)
		else $error("input ready during conversion");

endmodule

`default_nettype wire

// ===== rtl/core/pif_dp.sv =====
`default_nettype none

module pif_dp #(
	parameter int MAX_FIELD = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire pif_pkg::cfg_t                    cfg,
	input  wire logic [pif_pkg::VALUE_W-1:0]      value_bits,
	input  wire pif_pkg::cmd_t                    cmd,
	output pif_pkg::sts_t                         sts,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [pif_pkg::CHAR_W-1:0]            char_out,
	output logic                                  last_char
);

	localparam int CW = $clog2(MAX_FIELD + 1);
	localparam logic [7:0] MAX_F8 = 8'(MAX_FIELD);

	logic [pif_pkg::VALUE_W-1:0]  mag_q;
	logic [pif_pkg::BCD_W-1:0]    bcd_q;
	logic [pif_pkg::BCD_W-1:0]    bcd_adj;
	logic [pif_pkg::NDIG_W-1:0]   nd_q;
	logic                         sign_q;
	logic [pif_pkg::CHAR_W-1:0]   sign_char_q;
	logic [CW-1:0]                pad_q;
	logic [CW-1:0]                zeros_q;
	logic [CW-1:0]                rem_q;
	logic                         out_valid_q;
	logic [pif_pkg::CHAR_W-1:0]   char_q;
	logic                         last_q;

	logic [pif_pkg::VALUE_W-1:0]  v_masked;
	logic [pif_pkg::VALUE_W-1:0]  v_neg;
	logic                         top_bit;
	logic                         is_neg;

	logic [7:0] nd8;
	logic [7:0] md8;
	logic [7:0] fw8;
	logic [7:0] zeros8;
	logic [7:0] room8;
	logic [7:0] tl8;
	logic [7:0] w8;
	logic [7:0] total8;

	logic [pif_pkg::CHAR_W-1:0]   char_d;
	logic [3:0]                   top_digit;

	function automatic logic [pif_pkg::VALUE_W-1:0] len_mask(
		input logic [1:0]                  mode,
		input logic [pif_pkg::VALUE_W-1:0] v
	);
		logic [pif_pkg::VALUE_W-1:0] r;
		case (mode)
			pif_pkg::LEN_SHORT: r = {48'd0, v[15:0]};
			pif_pkg::LEN_LONG:  r = v;
			default:            r = {32'd0, v[31:0]};
		endcase
		return r;
	endfunction

	// Length cut, sign detection and magnitude.
	always_comb begin
		v_masked = len_mask(cfg.length_mode, value_bits);
		case (cfg.length_mode)
			pif_pkg::LEN_SHORT: top_bit = value_bits[15];
			pif_pkg::LEN_LONG:  top_bit = value_bits[63];
			default:            top_bit = value_bits[31];
		endcase
		is_neg = !cfg.conv_unsigned && top_bit;
		v_neg  = len_mask(cfg.length_mode, (~v_masked) + 64'd1);
	end

	// Add-three correction on every digit before the shift.
	always_comb begin
		for (int i = 0; i < pif_pkg::BCD_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ?
				bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
		end
	end

	assign top_digit = bcd_q[pif_pkg::BCD_W-1 -: 4];

	// Field layout from the digit count and the configuration.
	always_comb begin
		nd8  = 8'(nd_q);
		md8  = 8'(cfg.min_digits);
		fw8  = 8'(cfg.field_width);
		room8 = MAX_F8 - nd8 - 8'(sign_q);
		zeros8 = 8'd0;
		if (!cfg.conv_unsigned && cfg.precision_on && md8 > nd8) begin
			zeros8 = md8 - nd8;
			if (zeros8 > room8) zeros8 = room8;
		end
		tl8    = 8'(sign_q) + zeros8 + nd8;
		w8     = (fw8 > MAX_F8) ? MAX_F8 : fw8;
		total8 = (w8 > tl8) ? w8 : tl8;
	end

	// Character selection: leading pad, sign, zeros, digits, trailing pad.
	always_comb begin
		if (!cfg.left_justify && pad_q != '0) begin
			char_d = pif_pkg::CHAR_SPACE;
		end else if (sign_q) begin
			char_d = sign_char_q;
		end else if (zeros_q != '0) begin
			char_d = pif_pkg::CHAR_ZERO;
		end else if (nd_q != '0) begin
			char_d = pif_pkg::CHAR_ZERO | {4'd0, top_digit};
		end else begin
			char_d = pif_pkg::CHAR_SPACE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nd_q        <= '0;
			sign_q      <= 1'b0;
			pad_q       <= '0;
			zeros_q     <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				nd_q   <= pif_pkg::NDIG_W'(pif_pkg::BCD_DIGITS);
				sign_q <= is_neg || (!cfg.conv_unsigned && (cfg.plus_sign || cfg.space_sign));
			end else if (cmd.norm) begin
				nd_q <= nd_q - 1'b1;
			end else if (cmd.layout) begin
				zeros_q <= CW'(zeros8);
				pad_q   <= CW'(total8 - tl8);
				rem_q   <= CW'(total8);
			end else if (cmd.emit) begin
				rem_q <= rem_q - 1'b1;
				if (!cfg.left_justify && pad_q != '0) begin
					pad_q <= pad_q - 1'b1;
				end else if (sign_q) begin
					sign_q <= 1'b0;
				end else if (zeros_q != '0) begin
					zeros_q <= zeros_q - 1'b1;
				end else if (nd_q != '0) begin
					nd_q <= nd_q - 1'b1;
				end else begin
					pad_q <= pad_q - 1'b1;
				end
			end

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q       <= is_neg ? v_neg : v_masked;
			bcd_q       <= '0;
			sign_char_q <= is_neg ? pif_pkg::CHAR_MINUS :
				(cfg.plus_sign ? pif_pkg::CHAR_PLUS : pif_pkg::CHAR_SPACE);
		end else if (cmd.dabble) begin
			bcd_q <= {bcd_adj[pif_pkg::BCD_W-2:0], mag_q[pif_pkg::VALUE_W-1]};
			mag_q <= {mag_q[pif_pkg::VALUE_W-2:0], 1'b0};
		end else if (cmd.norm) begin
			bcd_q <= {bcd_q[pif_pkg::BCD_W-5:0], 4'd0};
		end else if (cmd.emit && (cfg.left_justify || pad_q == '0) && !sign_q &&
			zeros_q == '0 && nd_q != '0) begin
			bcd_q <= {bcd_q[pif_pkg::BCD_W-5:0], 4'd0};
		end

		if (cmd.emit) begin
			char_q <= char_d;
			last_q <= (rem_q == CW'(1));
		end
	end

	assign sts.norm_done = (top_digit != 4'd0) || (nd_q == pif_pkg::NDIG_W'(1));
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.last      = (rem_q == CW'(1));

	assign out_valid = out_valid_q;
	assign char_out  = char_q;
	assign last_char = last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> rem_q != '0)
		else $error("character emitted with nothing left in the field");

	assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.layout) |-> rem_q != '0 && 8'(rem_q) <= MAX_F8)
		else $error("field length out of range after layout");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && rem_q == CW'(1)) |=>
		pad_q == '0 && zeros_q == '0 && nd_q == '0 && !sign_q)
		else $error("field ended with characters still pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.norm |-> nd_q > pif_pkg::NDIG_W'(1))
		else $error("normalisation would drop the last digit");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import pif_pkg::*;

	// The block is built with the widest field, so a single value can produce up to
	// 64 characters.
	localparam int FIELD_LIMIT     = 64;
	localparam int RESET_CYCLES    = 7;
	localparam int RANDOM_PHASES   = 12;
	localparam int ITEMS_PER_PHASE = 30;
	localparam int QUIET_PHASE     = 3;
	localparam int HOLD_PHASE      = 6;
	localparam int HOLD_CYCLES     = 500;
	localparam int SETTLE_CYCLES   = 4;
	localparam int TAIL_CYCLES     = 200;
	localparam int CYCLE_LIMIT     = 600_000;
	localparam int IDLE_PERCENT    = 37;

	// The fourth length code is not named in the package; it must behave as int.
	localparam logic [1:0] LEN_UNUSED = 2'd3;

	// One character of a formatted field, as it should leave on the output stream.
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} field_char_t;

	// A row of the directed table: the format to load, the raw value, and the text that
	// must come out. An empty text means the row is checked against the predictor.
	typedef struct {
		cfg_t        format;
		logic [63:0] value;
		string       text;
	} directed_row_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [VALUE_W-1:0]   s_axis_tdata  = '0;   // [63:0] value_bits
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [CHAR_W-1:0]    m_axis_tdata;          // [7:0] char_out
	logic                 m_axis_tlast;
	logic                 cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	// Format currently held by the block, as the predictor sees it.
	cfg_t        active_format = '0;
	// Characters still owed by the block, oldest first.
	field_char_t expected_chars[$];

	int error_count  = 0;
	int cycle_count  = 0;
	int hold_request = 0;
	bit tx_idle_on   = 1'b1;
	bit rx_idle_on   = 1'b1;

	// Directed table. Columns of the format are: unsigned, length, left justify, plus,
	// space, field width, precision on, minimum digits.
	directed_row_t directed_rows [25] = '{
		// Reset format: plain signed int, no padding.
		'{'{0, LEN_INT,    0, 0, 0,   0, 0,  0}, 64'h0000_0000_0000_0000, "0"},
		'{'{0, LEN_INT,    0, 0, 0,   0, 0,  0}, 64'h0000_0000_FFFF_FFFF, "-1"},
		'{'{0, LEN_INT,    0, 0, 0,   0, 0,  0}, 64'h0000_0000_7FFF_FFFF, "2147483647"},
		'{'{0, LEN_INT,    0, 0, 0,   0, 0,  0}, 64'h0000_0000_8000_0000, "-2147483648"},
		'{'{0, LEN_INT,    0, 0, 0,   0, 0,  0}, 64'hFFFF_FFFF_0000_002A, "42"},
		// Short and the unused length code.
		'{'{0, LEN_SHORT,  0, 0, 0,   0, 0,  0}, 64'h0000_0000_0000_8000, "-32768"},
		'{'{0, LEN_SHORT,  0, 0, 0,   0, 0,  0}, 64'hFFFF_FFFF_FFFF_7FFF, "32767"},
		'{'{0, LEN_UNUSED, 0, 0, 0,   0, 0,  0}, 64'h0000_0000_FFFF_FFFF, "-1"},
		// Long: the most negative value must come out exact.
		'{'{0, LEN_LONG,   0, 0, 0,   0, 0,  0}, 64'h8000_0000_0000_0000,
			"-9223372036854775808"},
		'{'{0, LEN_LONG,   0, 0, 0,   0, 0,  0}, 64'h7FFF_FFFF_FFFF_FFFF,
			"9223372036854775807"},
		// Unsigned conversion; sign flags and precision must have no effect.
		'{'{1, LEN_LONG,   0, 0, 0,   0, 0,  0}, 64'hFFFF_FFFF_FFFF_FFFF,
			"18446744073709551615"},
		'{'{1, LEN_SHORT,  0, 0, 0,   0, 0,  0}, 64'h0000_0000_0000_FFFF, "65535"},
		'{'{1, LEN_INT,    0, 1, 1,   0, 1, 10}, 64'h0000_0000_0000_0005, "5"},
		// Sign prefixes: plus wins over space, and neither touches a negative value.
		'{'{0, LEN_INT,    0, 1, 0,   0, 0,  0}, 64'h0000_0000_0000_0007, "+7"},
		'{'{0, LEN_INT,    0, 1, 1,   0, 0,  0}, 64'h0000_0000_0000_0000, "+0"},
		'{'{0, LEN_INT,    0, 0, 1,   0, 0,  0}, 64'h0000_0000_0000_0007, " 7"},
		'{'{0, LEN_INT,    0, 0, 1,   0, 0,  0}, 64'h0000_0000_FFFF_FFF9, "-7"},
		// Precision: zero still prints a digit, and the minus sign leads the zeros.
		'{'{0, LEN_INT,    0, 0, 0,   0, 1,  0}, 64'h0000_0000_0000_0000, "0"},
		'{'{0, LEN_INT,    0, 0, 0,   0, 1,  5}, 64'h0000_0000_FFFF_FFD6, "-00042"},
		// Field width, both justifications, and text longer than the width.
		'{'{0, LEN_INT,    0, 0, 0,   6, 0,  0}, 64'd42, "    42"},
		'{'{0, LEN_INT,    1, 0, 0,   6, 0,  0}, 64'd42, "42    "},
		'{'{0, LEN_INT,    0, 0, 0,   5, 0,  0}, 64'd123456, "123456"},
		// Oversized width and precision are clipped to the field limit.
		'{'{0, LEN_INT,    0, 0, 0, 127, 0,  0}, 64'h0000_0000_0000_0000, ""},
		'{'{0, LEN_LONG,   0, 1, 0,   0, 1, 63}, 64'h0000_0000_0000_0001, ""},
		'{'{0, LEN_LONG,   1, 0, 1,  64, 1, 63}, 64'h8000_0000_0000_0000, ""}
	};

	printf_integer_formatter #(
		.MAX_FIELD(FIELD_LIMIT)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Bits of the raw value that survive the length truncation.
	function automatic logic [63:0] length_mask(input logic [1:0] code);
		case (code)
			LEN_SHORT: return 64'h0000_0000_0000_FFFF;
			LEN_LONG:  return 64'hFFFF_FFFF_FFFF_FFFF;
			default:   return 64'h0000_0000_FFFF_FFFF;
		endcase
	endfunction

	// Works out the field that the active format gives for one raw value and appends its
	// characters to the expected stream. The sign, the leading zeros and the digits make
	// up the text; spaces then pad it to the field width on one side or the other.
	function automatic void format_decimal(input logic [63:0] raw);
		logic [63:0]       mask;
		logic [63:0]       magnitude;
		logic [CHAR_W-1:0] sign_char;
		logic [CHAR_W-1:0] digits[$];
		logic [CHAR_W-1:0] text[$];
		logic [CHAR_W-1:0] c;
		int                zeros;
		int                room;
		int                width;
		int                total;
		int                pad;
		mask      = length_mask(active_format.length_mode);
		magnitude = raw & mask;
		sign_char = 8'd0;
		if (!active_format.conv_unsigned) begin
			// Negating within the mask keeps the most negative value exact.
			if ((magnitude & ((mask >> 1) + 64'd1)) != 64'd0) begin
				magnitude = (64'd0 - magnitude) & mask;
				sign_char = CHAR_MINUS;
			end else if (active_format.plus_sign) begin
				sign_char = CHAR_PLUS;
			end else if (active_format.space_sign) begin
				sign_char = CHAR_SPACE;
			end
		end
		do begin
			digits.push_front(CHAR_ZERO + 8'(magnitude % 64'd10));
			magnitude = magnitude / 64'd10;
		end while (magnitude != 64'd0);
		zeros = 0;
		if (!active_format.conv_unsigned && active_format.precision_on &&
				int'(active_format.min_digits) > digits.size()) begin
			zeros = int'(active_format.min_digits) - digits.size();
			room  = FIELD_LIMIT - digits.size() - ((sign_char != 8'd0) ? 1 : 0);
			if (zeros > room) begin
				zeros = room;
			end
		end
		if (sign_char != 8'd0) begin
			text.push_back(sign_char);
		end
		repeat (zeros) text.push_back(CHAR_ZERO);
		foreach (digits[i]) text.push_back(digits[i]);
		width = (int'(active_format.field_width) > FIELD_LIMIT) ? FIELD_LIMIT :
			int'(active_format.field_width);
		total = (width > text.size()) ? width : text.size();
		pad   = total - text.size();
		for (int k = 0; k < total; k++) begin
			if (active_format.left_justify) begin
				c = (k < text.size()) ? text[k] : CHAR_SPACE;
			end else begin
				c = (k < pad) ? CHAR_SPACE : text[k - pad];
			end
			expected_chars.push_back('{c, (k == total - 1)});
		end
	endfunction

	// Random raw values, chosen so that every digit count, the sign boundaries of the
	// current length and garbage above the truncation point all turn up.
	function automatic logic [63:0] random_value();
		logic [63:0] mask;
		logic [63:0] noise;
		logic [63:0] top;
		logic [63:0] edge_value;
		mask  = length_mask(active_format.length_mode);
		noise = {$urandom, $urandom};
		top   = (mask >> 1) + 64'd1;
		case ($urandom_range(5))
			0: begin
				case ($urandom_range(4))
					0:       edge_value = 64'd0;
					1:       edge_value = 64'd1;
					2:       edge_value = top - 64'd1;
					3:       edge_value = top;
					default: edge_value = mask;
				endcase
				return (noise & ~mask) | edge_value;
			end
			1:       return 64'($urandom_range(999));
			2:       return 64'd0 - 64'($urandom_range(1, 999));
			3:       return noise >> $urandom_range(63);
			default: return noise;
		endcase
	endfunction

	function automatic cfg_t random_format();
		cfg_t f;
		f.conv_unsigned = ($urandom_range(2) == 0);
		f.length_mode   = 2'($urandom_range(3));
		f.left_justify  = 1'($urandom_range(1));
		f.plus_sign     = 1'($urandom_range(1));
		f.space_sign    = 1'($urandom_range(1));
		case ($urandom_range(7))
			0:       f.field_width = 7'd0;
			1:       f.field_width = 7'd64;
			2:       f.field_width = 7'($urandom_range(65, 127));
			default: f.field_width = 7'($urandom_range(25));
		endcase
		f.precision_on = 1'($urandom_range(1));
		case ($urandom_range(5))
			0:       f.min_digits = 6'd0;
			1:       f.min_digits = 6'd63;
			2:       f.min_digits = 6'($urandom_range(20, 40));
			default: f.min_digits = 6'($urandom_range(22));
		endcase
		return f;
	endfunction

	task automatic put_reg(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// Loads every register of a format. The bits above a narrow register's width carry
	// noise, which the block has to ignore.
	task automatic apply_format(input cfg_t f);
		put_reg(REG_CONV_UNSIGNED, {6'($urandom), f.conv_unsigned});
		put_reg(REG_LENGTH_MODE,   {5'($urandom), f.length_mode});
		put_reg(REG_LEFT_JUSTIFY,  {6'($urandom), f.left_justify});
		put_reg(REG_PLUS_SIGN,     {6'($urandom), f.plus_sign});
		put_reg(REG_SPACE_SIGN,    {6'($urandom), f.space_sign});
		put_reg(REG_FIELD_WIDTH,   f.field_width);
		put_reg(REG_PRECISION_ON,  {6'($urandom), f.precision_on});
		put_reg(REG_MIN_DIGITS,    {1'($urandom), f.min_digits});
		cfg_we <= 1'b0;
		active_format = f;
	endtask

	// Offers one value, with random idle cycles ahead of it, and records what it must
	// produce once the transaction has gone through. A typed text stands in for the
	// predictor on directed rows that carry one.
	task automatic send_value(input logic [63:0] value, input string typed);
		while (tx_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		if (typed.len() == 0) begin
			format_decimal(value);
		end else begin
			for (int i = 0; i < typed.len(); i++) begin
				expected_chars.push_back('{typed[i], (i == typed.len() - 1)});
			end
		end
	endtask

	// Stops offering and waits until every owed character has arrived; the block then
	// has nothing in flight, so the format may be changed.
	task automatic drain_fields();
		s_axis_tvalid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Output side: checks each transaction against the oldest owed character, then
	// decides the ready for the next cycle. A requested hold-off keeps ready low for a
	// long stretch so that the block backs up and stalls its input.
	always @(posedge clk) begin : char_sink
		field_char_t want;
		int          hold_left;
		int          hold_served;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_chars.size() == 0) begin
				$display("%0t ns: unexpected character, expected none, got 0x%02h last %0b",
					$time, m_axis_tdata, m_axis_tlast);
				error_count++;
			end else begin
				want = expected_chars.pop_front();
				if (m_axis_tdata !== want.ch) begin
					$display("%0t ns: char_out mismatch, expected 0x%02h, got 0x%02h",
						$time, want.ch, m_axis_tdata);
					error_count++;
				end
				if (m_axis_tlast !== want.last) begin
					$display("%0t ns: last_char mismatch, expected %0b, got %0b",
						$time, want.last, m_axis_tlast);
					error_count++;
				end
			end
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_served != hold_request) begin
			hold_served = hold_request;
			hold_left   = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !(rx_idle_on && $urandom_range(99) < IDLE_PERCENT);
		end
	end

	// Guards against a hang anywhere in the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : stimulus
		cfg_t phase_format;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows. The format is only reloaded when a row asks for a different one,
		// and only once the block has emptied.
		foreach (directed_rows[r]) begin
			if (directed_rows[r].format != active_format) begin
				drain_fields();
				apply_format(directed_rows[r].format);
			end
			send_value(directed_rows[r].value, directed_rows[r].text);
		end

		// Random phases, each under a format of its own. The first two use the extremes;
		// one phase runs with no idling on either side, and one starts with a long
		// receiver hold-off while values keep coming.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_fields();
			case (phase)
				0:       phase_format = '{0, LEN_LONG, 1, 1, 1, 7'd64, 1, 6'd63};
				1:       phase_format = '{1, LEN_UNUSED, 0, 1, 0, 7'd127, 1, 6'd63};
				default: phase_format = random_format();
			endcase
			apply_format(phase_format);
			tx_idle_on = (phase != QUIET_PHASE);
			rx_idle_on <= (phase != QUIET_PHASE);
			if (phase == HOLD_PHASE) begin
				hold_request <= hold_request + 1;
			end
			repeat (ITEMS_PER_PHASE) send_value(random_value(), "");
		end

		drain_fields();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/pif_pkg.sv
rtl/core/pif_ctrl.sv
rtl/core/pif_dp.sv
rtl/core/printf_integer_formatter.sv
tb/testbench.sv
